/* hdl/jsd_pkg.sv */
// Package for the job sequencing unit: sizes, the job record and the phase codes.
// Used by jsd_cell and job_sequencing_with_deadlines_unit; depends on nothing.
package jsd_pkg;
  localparam int MaxJobs  = 16;
  localparam int MaxSlots = 16;
  localparam int CntW     = $clog2(MaxJobs + 1);
  localparam int IdxW     = $clog2(MaxJobs);
  localparam int SlotW    = $clog2(MaxSlots);
  localparam int DlW      = 5;
  localparam int SumW     = 20;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // One stored job as it travels along the chain. The push bit marks a job
  // that has been moved on by a higher profit during an insertion.
  typedef struct packed {
    logic        vld;
    logic        push;
    logic [7:0]  id;
    logic [DlW-1:0] dl;
    logic [15:0] profit;
  } job_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StSettle = 5'b00010,
    StPlace  = 5'b00100,
    StEmit   = 5'b01000,
    StDone   = 5'b10000
  } state_e;
endpackage

/* hdl/job_sequencing_with_deadlines_unit.sv */
// Top level of the job sequencing unit: sorting chain, slot placer, emitter.
// Depends on jsd_pkg and jsd_cell.
//
//  channel | handshake      | fields
//  job in  | start_i, busy_o | job_id_i job_deadline_i job_profit_i last_job_i
//  result  | res_valid_o    | slot_index_o sched_job_id_o job_valid_o
//          |                | total_profit_o overflow_o last_result_o
//
// A non-final job leaves the unit idle for the next one: it enters cell 0 and
// its insertion moves on one cell per cycle. After the last job the chain
// settles (StSettle), then shifts one job per cycle into the slot placer.
// The slot table is then scanned one slot per cycle up to the last placed slot
// (at most MaxSlots slots; a single empty beat when nothing is placed), and a
// closing state (StDone) follows. Reset clears the chain and slot valid bits
// at once. The receiver cannot stall: each result beat is shown for one cycle.
module job_sequencing_with_deadlines_unit import jsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  job_id_i,
  input  logic [4:0]  job_deadline_i,
  input  logic [15:0] job_profit_i,
  input  logic        last_job_i,
  output logic        res_valid_o,
  output logic [3:0]  slot_index_o,
  output logic [7:0]  sched_job_id_o,
  output logic        job_valid_o,
  output logic [19:0] total_profit_o,
  output logic        overflow_o,
  output logic        last_result_o
);
  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic drop_q, drop_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [IdxW:0] step_q, step_d;
  logic [MaxSlots-1:0] used_q, used_d;
  logic [7:0] sid_q [MaxSlots];
  logic [SlotW-1:0] scan_q, scan_d;
  logic [SlotW:0] left_q, left_d;

  job_t chain_in;
  job_t cell_job [MaxJobs];
  job_t cell_pass [MaxJobs];
  logic accept, ins, shift, clr;

  assign accept = start_i && state_q == StIdle;
  assign busy_o = state_q != StIdle;
  assign ins    = accept && cnt_q < CntW'(MaxJobs);
  assign shift  = state_q == StPlace;
  assign clr    = state_q == StDone;

  always_comb begin
    chain_in.vld    = ins;
    chain_in.push   = 1'b0;
    chain_in.id     = job_id_i;
    chain_in.dl     = job_deadline_i;
    chain_in.profit = job_profit_i;
  end

  // The chain: cell 0 holds the highest profit; shifting moves jobs to 0.
  for (genvar g = 0; g < MaxJobs; g++) begin : g_cell
    job_t prev;
    if (g == 0) begin : g_first
      assign prev = shift ? cell_job[1 % MaxJobs] : chain_in;
    end else if (g == MaxJobs - 1) begin : g_end
      assign prev = shift ? '0 : cell_pass[g-1];
    end else begin : g_mid
      assign prev = shift ? cell_job[g+1] : cell_pass[g-1];
    end
    jsd_cell u_cell (
      .clk_i, .rst_ni, .clr_i(clr), .shift_i(shift),
      .prev_i(prev), .job_o(cell_job[g]), .pass_o(cell_pass[g])
    );
  end

  // Placement of the head job: latest free slot below its clamped deadline.
  job_t head;
  logic [DlW-1:0] dcl;
  logic found;
  logic [SlotW-1:0] fslot;
  logic [SumW:0] sum_add;
  assign head = cell_job[0];
  assign dcl  = (head.dl > DlW'(MaxSlots)) ? DlW'(MaxSlots) : head.dl;
  always_comb begin
    found = 1'b0;
    fslot = '0;
    for (int s = 0; s < MaxSlots; s++) begin
      if (DlW'(s) < dcl && !used_q[s]) begin
        found = 1'b1;
        fslot = SlotW'(s);
      end
    end
  end
  assign sum_add = {1'b0, sum_q} + (SumW+1)'(head.profit);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    sum_d   = sum_q;
    step_d  = step_q;
    used_d  = used_q;
    scan_d  = scan_q;
    left_d  = left_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (ins) cnt_d = cnt_q + 1'b1;
          else drop_d = 1'b1;
          if (last_job_i) begin
            state_d = StSettle;
            step_d  = '0;
            used_d  = '0;
            sum_d   = '0;
            left_d  = '0;
          end
        end
      end
      StSettle: begin
        // Wait until the last insertion has reached the end of the chain.
        step_d = step_q + 1'b1;
        if (step_q == (IdxW+1)'(MaxJobs - 2)) begin
          state_d = StPlace;
          step_d  = '0;
        end
      end
      StPlace: begin
        if (head.vld && found) begin
          used_d[fslot] = 1'b1;
          sum_d  = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
          left_d = left_q + 1'b1;
        end
        step_d = step_q + 1'b1;
        if (step_q == (IdxW+1)'(MaxJobs - 1)) begin
          state_d = StEmit;
          scan_d  = '0;
        end
      end
      StEmit: begin
        if (left_q == '0) begin
          state_d = StDone;
        end else begin
          if (used_q[scan_q]) left_d = left_q - 1'b1;
          scan_d = scan_q + 1'b1;
          if (used_q[scan_q] && left_q == (SlotW+1)'(1)) state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
        cnt_d   = '0;
        drop_d  = 1'b0;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      sum_q   <= '0;
      step_q  <= '0;
      used_q  <= '0;
      scan_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      sum_q   <= sum_d;
      step_q  <= step_d;
      used_q  <= used_d;
      scan_q  <= scan_d;
      left_q  <= left_d;
    end
  end

  // Slot ids are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == StPlace && head.vld && found) sid_q[fslot] <= head.id;
  end

  // Result beat, registered.
  logic emit_now, emit_none, is_last;
  assign emit_now  = state_q == StEmit && left_q != '0 && used_q[scan_q];
  assign emit_none = state_q == StEmit && left_q == '0;
  assign is_last   = emit_none || (emit_now && left_q == (SlotW+1)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= emit_now || emit_none;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_index_o   <= emit_now ? 4'(scan_q) : 4'd0;
    sched_job_id_o <= emit_now ? sid_q[scan_q] : 8'd0;
    job_valid_o    <= emit_now;
    total_profit_o <= (emit_now && is_last) ? sum_q : '0;
    overflow_o     <= drop_q;
    last_result_o  <= is_last;
  end
endmodule

/* hdl/jsd_cell.sv */
// One cell of the sorting chain: holds one job and swaps with the incoming job.
// Depends on jsd_pkg.
module jsd_cell import jsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clr_i,
  input  logic shift_i,
  input  job_t prev_i,
  output job_t job_o,
  output job_t pass_o
);
  job_t job_q, job_d;
  job_t pass_q, pass_d;

  // A fresh job takes the cell only from a strictly lower profit, so ties keep
  // arrival order. A job that was pushed on belongs ahead of everything behind
  // it and always takes the cell. The loser moves on one cell per cycle.
  always_comb begin
    job_d  = job_q;
    pass_d = '0;
    if (shift_i) begin
      job_d = prev_i;
    end else if (prev_i.vld) begin
      if (!job_q.vld || prev_i.push || job_q.profit < prev_i.profit) begin
        job_d       = prev_i;
        pass_d      = job_q;
        pass_d.push = 1'b1;
      end else begin
        pass_d = prev_i;
      end
    end
    if (clr_i) job_d.vld = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q  <= '0;
      pass_q <= '0;
    end else begin
      job_q  <= job_d;
      pass_q <= pass_d;
    end
  end

  assign job_o  = job_q;
  assign pass_o = pass_q;
endmodule
